FILE: src/ps2md_pkg.sv
package ps2md_pkg;

  // Command carried in tuser of the input channel
  typedef enum logic [1:0] {
    CMD_BYTE         = 2'd0,
    CMD_STATUS       = 2'd1,
    CMD_CLEAR_ALL    = 2'd2,
    CMD_CLEAR_MOTION = 2'd3
  } cmd_t;

  // Packet assembly phase, one-hot
  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_DX     = 3'b010,
    PH_DY     = 3'b100
  } phase_t;

  localparam logic KIND_PACKET = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [7:0] BUTTON_MASK   = 8'h07;
  localparam logic [7:0] CHANGE_MASK   = 8'h38;
  localparam logic [7:0] MOVE_BIT      = 8'h40;
  localparam logic [7:0] OVERFLOW_BITS = 8'hc0;

  // Decoder state kept between requests
  typedef struct packed {
    phase_t             phase;
    logic [7:0]         held_buttons;
    logic [7:0]         held_dx;
    logic [7:0]         prev_buttons;
    logic [7:0]         status_bits;
    logic signed [15:0] accum_x;
    logic signed [15:0] accum_y;
  } dec_state_t;

  // Results produced by one request, loaded into the output buffer
  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] hdr;
    logic [7:0] dx;
    logic [7:0] dy;
    logic [7:0] status;
    logic [7:0] x_motion;
    logic [7:0] y_motion;
  } bundle_t;

  // Saturating add of a signed byte into a 16-bit accumulator
  function automatic logic signed [15:0] sat_add16(input logic signed [15:0] a,
                                                   input logic [7:0] d);
    logic signed [16:0] s;
    s = {a[15], a} + {{9{d[7]}}, d};
    if (s[16] != s[15]) begin
      sat_add16 = s[16] ? 16'sh8000 : 16'sh7fff;
    end else begin
      sat_add16 = s[15:0];
    end
  endfunction

  // Clamp a 16-bit signed value to a signed byte
  function automatic logic [7:0] clamp8(input logic signed [15:0] a);
    if (!a[15] && (a[14:7] != 8'h00)) begin
      clamp8 = 8'h7f;
    end else if (a[15] && (a[14:7] != 8'hff)) begin
      clamp8 = 8'h80;
    end else begin
      clamp8 = a[7:0];
    end
  endfunction

endpackage

FILE: src/ps2md_step.sv
module ps2md_step (
  input  ps2md_pkg::cmd_t       cmd,
  input  logic [7:0]            mouse_byte,
  input  logic                  device_open,
  input  ps2md_pkg::dec_state_t cur,
  output ps2md_pkg::dec_state_t nxt,
  output ps2md_pkg::bundle_t    res
);

  logic [7:0] ext_b;
  logic [7:0] dy;
  logic [7:0] changed;

  // Sign extension from bit 5, Y negated
  assign ext_b   = {{2{mouse_byte[5]}}, mouse_byte[5:0]};
  assign dy      = 8'd0 - ext_b;
  assign changed = cur.held_buttons ^ cur.prev_buttons;

  // State update and result bundle for one request
  always_comb begin
    nxt = cur;
    res = '0;
    case (cmd)
      ps2md_pkg::CMD_STATUS: begin
        res.valid    = 1'b1;
        res.kind     = ps2md_pkg::KIND_STATUS;
        res.status   = cur.status_bits |
                       (((cur.accum_x != 16'sd0) || (cur.accum_y != 16'sd0)) ?
                        ps2md_pkg::MOVE_BIT : 8'h00);
        res.x_motion = ps2md_pkg::clamp8(cur.accum_x);
        res.y_motion = ps2md_pkg::clamp8(cur.accum_y);
        nxt.accum_x     = '0;
        nxt.accum_y     = '0;
        nxt.status_bits = cur.status_bits & ~ps2md_pkg::CHANGE_MASK;
      end
      ps2md_pkg::CMD_CLEAR_ALL: begin
        nxt.status_bits  = '0;
        nxt.prev_buttons = '0;
        nxt.accum_x      = '0;
        nxt.accum_y      = '0;
      end
      ps2md_pkg::CMD_CLEAR_MOTION: begin
        nxt.accum_x = '0;
        nxt.accum_y = '0;
      end
      ps2md_pkg::CMD_BYTE: begin
        case (cur.phase)
          ps2md_pkg::PH_DX: begin
            nxt.held_dx = ext_b;
            nxt.phase   = ps2md_pkg::PH_DY;
          end
          ps2md_pkg::PH_DY: begin
            nxt.phase        = ps2md_pkg::PH_HEADER;
            nxt.prev_buttons = cur.held_buttons;
            nxt.status_bits  = cur.held_buttons |
                               (cur.status_bits & ~ps2md_pkg::BUTTON_MASK) |
                               {changed[4:0], 3'b000};
            nxt.accum_x      = ps2md_pkg::sat_add16(cur.accum_x, cur.held_dx);
            nxt.accum_y      = ps2md_pkg::sat_add16(cur.accum_y, dy);
            if (device_open &&
                ((cur.held_dx != 8'h00) || (dy != 8'h00) || (changed != 8'h00))) begin
              res.valid = 1'b1;
              res.kind  = ps2md_pkg::KIND_PACKET;
              res.hdr   = ps2md_pkg::MOVE_BIT |
                          (cur.held_buttons ^ ps2md_pkg::BUTTON_MASK);
              res.dx    = cur.held_dx;
              res.dy    = dy;
            end
          end
          default: begin
            // header byte; overflow keeps us at the header
            nxt.held_buttons = ~{5'b00000, mouse_byte[0], mouse_byte[1], 1'b0};
            nxt.phase        = ((mouse_byte & ps2md_pkg::OVERFLOW_BITS) != 8'h00) ?
                               ps2md_pkg::PH_HEADER : ps2md_pkg::PH_DX;
          end
        endcase
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

FILE: src/ps2_mouse_packet_decoder_core.sv
// A request is registered on acceptance; its result is loaded from that input
// register into the output buffer, which then offers it on the output.
// Throughput: one request per cycle when it gives no result; results leave one
// per cycle while out_tready is high, so a packet request holds the buffer until its fifth result leaves.
// Reset (rst_n low, synchronous): decoder state and device_open clear to zero, the phase to PH_HEADER.
module ps2_mouse_packet_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // device_open
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // [7:0] mouse_byte
  input  logic [1:0]  in_tuser,      // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // [7:0] packet_byte, [15:8] status_octet,
                                     // [23:16] x_motion, [31:24] y_motion
  output logic        out_tuser,     // [0] kind
  output logic        out_tlast      // last_of_run
);

  logic                  dev_open_r;
  logic                  s1_valid_r;
  ps2md_pkg::cmd_t       s1_cmd_r;
  logic [7:0]            s1_byte_r;
  ps2md_pkg::dec_state_t st_r;
  ps2md_pkg::dec_state_t st_nxt;
  ps2md_pkg::bundle_t    res;

  logic       out_valid_r;
  logic       kind_r;
  logic [2:0] idx_r;
  logic [7:0] hdr_r;
  logic [7:0] dx_r;
  logic [7:0] dy_r;
  logic [7:0] stat_r;
  logic [7:0] xm_r;
  logic [7:0] ym_r;
  logic       out_last;
  logic       buf_free;
  logic       s1_adv;
  logic [7:0] pkt_byte;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_open_r <= 1'b0;
    end else if (cfg_wr_en) begin
      dev_open_r <= cfg_wr_data;
    end
  end

  // Output buffer frees when empty or its last result leaves
  assign out_last = (kind_r == ps2md_pkg::KIND_STATUS) || (idx_r == 3'd4);
  assign buf_free = !out_valid_r || (out_tready && out_last);
  assign s1_adv   = s1_valid_r && (!res.valid || buf_free);
  assign in_tready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r  <= ps2md_pkg::cmd_t'(in_tuser);
      s1_byte_r <= in_tdata;
    end
  end

  ps2md_step u_step (
    .cmd         (s1_cmd_r),
    .mouse_byte  (s1_byte_r),
    .device_open (dev_open_r),
    .cur         (st_r),
    .nxt         (st_nxt),
    .res         (res)
  );

  // Decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= '0;
      st_r.phase <= ps2md_pkg::PH_HEADER;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Output buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 3'd0;
    end else if (s1_adv && res.valid) begin
      out_valid_r <= 1'b1;
      idx_r       <= 3'd0;
    end else if (out_valid_r && out_tready) begin
      if (out_last) begin
        out_valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (s1_adv && res.valid) begin
      kind_r <= res.kind;
      hdr_r  <= res.hdr;
      dx_r   <= res.dx;
      dy_r   <= res.dy;
      stat_r <= res.status;
      xm_r   <= res.x_motion;
      ym_r   <= res.y_motion;
    end
  end

  // Packet byte select
  always_comb begin
    case (idx_r)
      3'd0:    pkt_byte = hdr_r;
      3'd1:    pkt_byte = dx_r;
      3'd2:    pkt_byte = dy_r;
      default: pkt_byte = 8'h00;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = kind_r;
  assign out_tlast  = out_last;
  assign out_tdata  = (kind_r == ps2md_pkg::KIND_STATUS) ?
                      {ym_r, xm_r, stat_r, 8'h00} : {24'h000000, pkt_byte};

`ifndef SYNTHESIS
  a_phase_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(st_r.phase))
    else $error("packet phase not one-hot");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (idx_r <= 3'd4))
    else $error("packet byte index out of range");

  a_status_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (kind_r == ps2md_pkg::KIND_STATUS)) |-> (idx_r == 3'd0))
    else $error("status report spans more than one result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && res.valid) |-> buf_free)
    else $error("result buffer overwritten before drained");
`endif

endmodule
